// ===== sv/mm_pkg.sv =====
// package for the matrix multiply block: item types, defaults and codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mm_pkg;

    localparam int MAX_DIM_DEF    = 8;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS      = 16;
    // wide enough to hold any dimension up to sixteen
    localparam int DIM_W          = 5;
    localparam int CFG_W          = 4;
    localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

    typedef enum logic [1:0] {
        ACT_LOAD_A  = 2'd0,
        ACT_LOAD_B  = 2'd1,
        ACT_COMPUTE = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_A_ROWS    = 2'd0,
        REG_INNER_DIM = 2'd1,
        REG_B_COLS    = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         row;
        logic [2:0]         col;
        logic signed [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] out_value;
        logic               last;
    } out_item_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic clr;
        logic ld;
        logic shift;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/mm_cell.sv =====
// one multiply-accumulate cell: holds one column of B and one result accumulator
// depends on mm_pkg
`timescale 1ns / 1ps
`default_nettype none

module mm_cell #(
    parameter int MAX_DIM = 8,
    parameter int DW      = 32,
    parameter int IDX_W   = 3,
    parameter int ACC_W   = 68
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire mm_pkg::cell_ctrl_t   ctrl,
    // a operand coming from the left neighbor
    input  wire logic [DW-1:0]        a_in,
    input  wire logic [IDX_W-1:0]     k_in,
    input  wire logic                 v_in,
    output logic [DW-1:0]             a_out,
    output logic [IDX_W-1:0]          k_out,
    output logic                      v_out,
    // b column write port
    input  wire logic                 b_we,
    input  wire logic [IDX_W-1:0]     b_addr,
    input  wire logic [DW-1:0]        b_wdata,
    // result shift chain toward cell zero
    input  wire logic [DW-1:0]        res_in,
    output logic [DW-1:0]             res_out
);
    import mm_pkg::*;

    logic [DW-1:0]          b_reg [MAX_DIM];
    logic signed [2*DW-1:0] prod_reg;
    logic                   prod_v_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] sh;
    logic [DW-1:0]          sat;
    logic [DW-1:0]          a_reg;
    logic [IDX_W-1:0]       k_reg;
    logic                   v_reg;
    logic [DW-1:0]          res_reg;

    localparam logic signed [ACC_W-1:0] MAXV = ACC_W'({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [ACC_W-1:0] MINV = ~MAXV;

    // b column storage
    always_ff @(posedge aclk) begin
        if (b_we) begin
            b_reg[b_addr] <= b_wdata;
        end
    end

    // operand forwarding to the right neighbor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else begin
            v_reg <= v_in;
        end
        a_reg <= a_in;
        k_reg <= k_in;
    end

    assign a_out = a_reg;
    assign k_out = k_reg;
    assign v_out = v_reg;

    // product stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_v_reg <= 1'b0;
        end else begin
            prod_v_reg <= v_in;
        end
        prod_reg <= $signed(a_in) * $signed(b_reg[k_in]);
    end

    // accumulate at full width
    always_comb begin
        acc_next = acc_reg + {{(ACC_W-2*DW){prod_reg[2*DW-1]}}, prod_reg};
    end

    always_ff @(posedge aclk) begin
        if (ctrl.clr) begin
            acc_reg <= '0;
        end else if (prod_v_reg) begin
            acc_reg <= acc_next;
        end
    end

    // drop fraction bits and saturate
    always_comb begin
        sh = acc_reg >>> FRAC_BITS;
        if (sh > MAXV) begin
            sat = MAXV[DW-1:0];
        end else if (sh < MINV) begin
            sat = MINV[DW-1:0];
        end else begin
            sat = sh[DW-1:0];
        end
    end

    // result capture and shift-out
    always_ff @(posedge aclk) begin
        if (ctrl.ld) begin
            res_reg <= sat;
        end else if (ctrl.shift) begin
            res_reg <= res_in;
        end
    end

    assign res_out = res_reg;

endmodule

`default_nettype wire

// ===== sv/matrix_multiply.sv =====
// top level of the matrix multiply block: sequencer, A store and the cell row
// depends on mm_pkg and mm_cell
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  ports
// s_        in         s_valid, s_ready, s_data (in_item_t)
// m_        out        m_valid, m_ready, m_data (out_item_t)
// cfg_      in         cfg_valid, cfg_ready, cfg_index, cfg_data
//
// load items are accepted while idle; a compute item runs, per row of C, inner_dim
// reads of A, a drain of the cell row, one capture and b_cols results (one per
// column, held back under m_ready stalls)
// the drain waits out the MAC pipeline of the cell row
// reset is synchronous active low and restores all dimensions to 8

module matrix_multiply #(
    parameter int MAX_DIM    = mm_pkg::MAX_DIM_DEF,
    parameter int DATA_WIDTH = mm_pkg::DATA_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire mm_pkg::in_item_t  s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output mm_pkg::out_item_t      m_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [3:0]        cfg_data
);
    import mm_pkg::*;

    localparam int DW        = DATA_WIDTH;
    localparam int IDX_W     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH     = MAX_DIM * MAX_DIM;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W     = 2 * DW + IDX_W + 1;
    localparam int DRAIN_LEN = MAX_DIM + 4;
    localparam int DRAIN_W   = $clog2(DRAIN_LEN + 1);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_FEED  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_LOAD  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [CFG_W-1:0]     a_rows_reg, inner_dim_reg, b_cols_reg;
    logic [DIM_W-1:0]     nr, nk, nc;
    logic [DIM_W-1:0]     i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [DRAIN_W-1:0]   drain_reg, drain_next;
    cell_ctrl_t           ctrl;
    logic                 s_fire, m_fire, out_load;
    logic [DIM_W-1:0]     row_w, col_w;
    logic                 in_range;
    logic [AW-1:0]        wr_addr, rd_addr;
    logic [DW-1:0]        a_mem [DEPTH];
    logic [DW-1:0]        rd_data_reg;
    logic                 rd_v_reg;
    logic [IDX_W-1:0]     rd_k_reg;
    logic                 m_valid_reg;
    out_item_t            m_data_reg;
    logic                 feeding;

    logic [DW-1:0]        a_link [MAX_DIM+1];
    logic [IDX_W-1:0]     k_link [MAX_DIM+1];
    logic                 v_link [MAX_DIM+1];
    logic [DW-1:0]        r_link [MAX_DIM+1];

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign m_fire    = m_valid_reg && m_ready;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_rows_reg    <= DIM_RESET;
            inner_dim_reg <= DIM_RESET;
            b_cols_reg    <= DIM_RESET;
        end else if (cfg_valid) begin
            unique case (reg_index_t'(cfg_index))
                REG_A_ROWS:    a_rows_reg    <= cfg_data;
                REG_INNER_DIM: inner_dim_reg <= cfg_data;
                REG_B_COLS:    b_cols_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp dimensions into one to MAX_DIM
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] d);
        logic [DIM_W-1:0] dw;
        dw = DIM_W'(d);
        if (dw == '0) begin
            return DIM_W'(1);
        end else if (dw > DIM_W'(MAX_DIM)) begin
            return DIM_W'(MAX_DIM);
        end
        return dw;
    endfunction

    assign nr = clamp_dim(a_rows_reg);
    assign nk = clamp_dim(inner_dim_reg);
    assign nc = clamp_dim(b_cols_reg);

    // load addressing
    assign row_w    = DIM_W'(s_data.row);
    assign col_w    = DIM_W'(s_data.col);
    assign in_range = (row_w < DIM_W'(MAX_DIM)) && (col_w < DIM_W'(MAX_DIM));
    assign wr_addr  = AW'(row_w) * AW'(MAX_DIM) + AW'(col_w);
    assign rd_addr  = AW'(i_reg) * AW'(MAX_DIM) + AW'(k_reg);
    assign feeding  = (state_reg == ST_FEED);

    // A store
    always_ff @(posedge aclk) begin
        if (s_fire && in_range && action_t'(s_data.action) == ACT_LOAD_A) begin
            a_mem[wr_addr] <= s_data.value[DW-1:0];
        end
        if (feeding) begin
            rd_data_reg <= a_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg <= 1'b0;
        end else begin
            rd_v_reg <= feeding;
        end
        rd_k_reg <= k_reg[IDX_W-1:0];
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        drain_next = drain_reg;
        ctrl       = '0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire && action_t'(s_data.action) == ACT_COMPUTE) begin
                    i_next     = '0;
                    k_next     = '0;
                    ctrl.clr   = 1'b1;
                    state_next = ST_FEED;
                end
            end
            ST_FEED: begin
                k_next = k_reg + 1'b1;
                if (k_reg == nk - 1'b1) begin
                    drain_next = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_W'(DRAIN_LEN - 1)) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                ctrl.ld    = 1'b1;
                j_next     = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    out_load   = 1'b1;
                    ctrl.shift = 1'b1;
                    j_next     = j_reg + 1'b1;
                    if (j_reg == nc - 1'b1) begin
                        if (i_reg == nr - 1'b1) begin
                            state_next = ST_IDLE;
                        end else begin
                            i_next     = i_reg + 1'b1;
                            k_next     = '0;
                            ctrl.clr   = 1'b1;
                            state_next = ST_FEED;
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            drain_reg <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
            drain_reg <= drain_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_fire) begin
            m_valid_reg <= 1'b0;
        end
        if (out_load) begin
            m_data_reg.out_row   <= i_reg[2:0];
            m_data_reg.out_col   <= j_reg[2:0];
            m_data_reg.out_value <= 32'(signed'(r_link[0]));
            m_data_reg.last      <= (i_reg == nr - 1'b1) && (j_reg == nc - 1'b1);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // cell row
    assign a_link[0] = rd_data_reg;
    assign k_link[0] = rd_k_reg;
    assign v_link[0] = rd_v_reg;
    assign r_link[MAX_DIM] = '0;

    for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
        logic b_we;
        assign b_we = s_fire && in_range && (action_t'(s_data.action) == ACT_LOAD_B)
                      && (col_w == DIM_W'(c));
        mm_cell #(
            .MAX_DIM (MAX_DIM),
            .DW      (DW),
            .IDX_W   (IDX_W),
            .ACC_W   (ACC_W)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .a_in    (a_link[c]),
            .k_in    (k_link[c]),
            .v_in    (v_link[c]),
            .a_out   (a_link[c+1]),
            .k_out   (k_link[c+1]),
            .v_out   (v_link[c+1]),
            .b_we    (b_we),
            .b_addr  (row_w[IDX_W-1:0]),
            .b_wdata (s_data.value[DW-1:0]),
            .res_in  (r_link[c+1]),
            .res_out (r_link[c])
        );
    end

`ifndef SYNTHESIS
    // a capture of results is always followed by emitting them
    a_load_then_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_LOAD |=> state_reg == ST_EMIT)
        else $error("result capture not followed by emit");

    // column counter never runs past the result width while emitting
    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT |-> j_reg < nc)
        else $error("column counter out of range");

    // inner index stays below inner_dim while reading A
    a_k_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FEED |-> k_reg < nk)
        else $error("inner index out of range");

    // no new item is taken while a run is in progress
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_IDLE |-> !s_ready)
        else $error("input accepted mid-run");
`endif

endmodule

`default_nettype wire
